// File: rtl/bric_pkg.sv
`timescale 1ns / 1ps

package bric_pkg;

  localparam int unsigned NumRates = 4;
  localparam int unsigned NumMults = 8;
  localparam int unsigned IntW     = 10;
  localparam int unsigned SrW      = 16;
  localparam int unsigned DenW     = 30;  // sample rate * 10000
  localparam int unsigned NumW     = 45;  // (n * baud) << 16 plus half divisor
  localparam int unsigned XW       = 31;  // normalized interval, Q16
  localparam int unsigned ErrW     = 17;  // Q0.16 error, includes 1.0
  localparam int unsigned FracW    = 17;
  localparam int unsigned DivCntW  = 6;

  localparam logic [IntW-1:0]  MinInterval = IntW'(12);
  localparam logic [IntW-1:0]  MaxInterval = IntW'(250);
  localparam logic [ErrW-1:0]  ErrLimit    = ErrW'(5243);
  localparam logic [ErrW-1:0]  ErrInit     = ErrW'(65536);
  localparam logic [33:0]      LockMin     = 34'd327680;
  localparam logic [13:0]      DenScale    = 14'd10000;
  localparam logic [DenW-1:0]  DecayDiv    = DenW'(5);
  localparam logic [SrW-1:0]   SrReset     = SrW'(2000);

  localparam logic [0:0] RegSampleRate = 1'b0;
  localparam logic [0:0] RegEnable     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_DIV,
    ST_ERR,
    ST_FRAC,
    ST_VOTE,
    ST_ADD,
    ST_NEXT,
    ST_SCAN,
    ST_CHECK,
    ST_DECAY,
    ST_DONE
  } state_e;

  // Baud rates in units of 1e-4 baud.
  function automatic logic [19:0] baud_e4(input logic [1:0] r);
    logic [19:0] b;
    case (r)
      2'd0:    b = 20'd454545;
      2'd1:    b = 20'd500000;
      2'd2:    b = 20'd750000;
      default: b = 20'd1000000;
    endcase
    return b;
  endfunction

  // Unit multiple in Q16 (half units * 32768).
  function automatic logic [18:0] mult_q16(input logic [2:0] m);
    logic [3:0] h;
    case (m)
      3'd0:    h = 4'd2;
      3'd1:    h = 4'd3;
      3'd2:    h = 4'd4;
      3'd3:    h = 4'd5;
      3'd4:    h = 4'd6;
      3'd5:    h = 4'd8;
      3'd6:    h = 4'd10;
      default: h = 4'd12;
    endcase
    return {h, 15'd0};
  endfunction

  function automatic logic [16:0] weight_q16(input logic [2:0] m);
    logic [16:0] w;
    case (m)
      3'd0:    w = 17'd65536;
      3'd1:    w = 17'd55706;
      3'd2:    w = 17'd32768;
      3'd3:    w = 17'd26214;
      3'd4:    w = 17'd9830;
      3'd5:    w = 17'd7373;
      3'd6:    w = 17'd5898;
      default: w = 17'd4915;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/baud_rate_interval_classifier_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+---------------------------------------
// in       | in  | in_valid_i / in_stall_o    | interval_samples_i
// out      | out | out_valid_o / out_stall_i  | accepted_o lock_event_o baud_index_o locked_o
// cfg      | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i cfg_data_i
//
// Sequence: one transaction at a time. A scored interval runs from acceptance to
//   result through a setup step, then per rate a load step, the shared
//   bit-serial restoring divider, a serial search over the eight multiples, a
//   fraction step, vote and add steps when the rate votes and a step to the
//   next rate (four rates), then an output step. A decision adds the scan and
//   check states, and a lock adds four divide-by-5 decays on the same divider.
//   An ignored interval goes straight to the output step.
// Reset: asynchronous active low; scores, counter, lock cleared, rate 2000 Hz,
//   enabled.
// Stalls: the result register holds one result; the next input is taken while
//   it waits, and the block only waits when a new result is ready and the old
//   one is still stalled.

module baud_rate_interval_classifier_top #(
  parameter int unsigned DECISION_WINDOW = 20,
  parameter int unsigned SCORE_BITS      = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bric_pkg::IntW-1:0] interval_samples_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      accepted_o,
  output logic                      lock_event_o,
  output logic [1:0]                baud_index_o,
  output logic                      locked_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [0:0]                cfg_index_i,
  input  logic [bric_pkg::SrW-1:0]  cfg_data_i
);

  localparam int unsigned SB = SCORE_BITS;
  localparam int unsigned SumW = SB + 2;
  localparam int unsigned CmpW = SB + 3;

  bric_pkg::state_e state_q, state_d;

  logic [bric_pkg::SrW-1:0]     sr_q;
  logic                         en_q;
  logic [SB-1:0]                score_q [bric_pkg::NumRates];
  logic [SB-1:0]                score_d [bric_pkg::NumRates];
  logic [7:0]                   cnt_q, cnt_d;
  logic                         lock_q, lock_d;
  logic [1:0]                   lock_idx_q, lock_idx_d;

  logic [7:0]                   n_q, n_d;
  logic [1:0]                   r_q, r_d;
  logic [2:0]                   m_q, m_d;
  logic [bric_pkg::DenW-1:0]    den_q, den_d;
  logic [bric_pkg::NumW-1:0]    num_q, num_d;     // dividend in, quotient out
  logic [bric_pkg::DenW-1:0]    rem_q, rem_d;
  logic [bric_pkg::DivCntW-1:0] dcnt_q, dcnt_d;
  logic                         decay_q, decay_d;
  logic [bric_pkg::ErrW-1:0]    berr_q, berr_d;
  logic [2:0]                   bm_q, bm_d;
  logic [bric_pkg::FracW-1:0]   frac_q, frac_d;
  logic [16:0]                  vote_q, vote_d;
  logic [SB-1:0]                best_q, best_d;
  logic [SB-1:0]                sec_q, sec_d;
  logic [1:0]                   bi_q, bi_d;
  logic                         acc_q, acc_d;
  logic                         evt_q, evt_d;

  logic                         ov_q, ov_d;
  logic                         oacc_q, oacc_d;
  logic                         oevt_q, oevt_d;
  logic [1:0]                   oidx_q, oidx_d;
  logic                         olock_q, olock_d;

  logic                         in_acc;
  logic                         cfg_wr;

  // datapath temporaries
  logic [bric_pkg::SrW-1:0]     sr_eff;
  logic [27:0]                  prod_nb;
  logic [bric_pkg::DenW:0]      trial;
  logic                         qbit;
  logic [bric_pkg::XW-1:0]      x;
  logic [bric_pkg::XW-1:0]      kq;
  logic [bric_pkg::XW-1:0]      e;
  logic [19:0]                  err100;
  logic [19:0]                  frac_full;
  logic [33:0]                  vprod;
  logic [SumW-1:0]              sum;
  logic [7:0]                   cnt_n;
  logic [CmpW-1:0]              five_best;
  logic [CmpW-1:0]              six_sec;

  assign in_stall_o   = (state_q != bric_pkg::ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr       = cfg_valid_i && cfg_ready_o;
  assign out_valid_o  = ov_q;
  assign accepted_o   = oacc_q;
  assign lock_event_o = oevt_q;
  assign baud_index_o = oidx_q;
  assign locked_o     = olock_q;

  assign sr_eff    = (sr_q == '0) ? bric_pkg::SrW'(1) : sr_q;
  assign prod_nb   = 28'(n_q * bric_pkg::baud_e4(r_q));
  assign trial     = {rem_q, num_q[bric_pkg::NumW-1]};
  assign qbit      = (trial >= {1'b0, den_q});
  assign x         = num_q[bric_pkg::XW-1:0];
  assign kq        = bric_pkg::XW'(bric_pkg::mult_q16(m_q));
  assign e         = (x > kq) ? (x - kq) : (kq - x);
  assign err100    = 20'(berr_q * 7'd100);
  assign frac_full = 20'd524288 - err100;
  assign vprod     = 34'(frac_q * bric_pkg::weight_q16(bm_q));
  assign sum       = SumW'(score_q[r_q]) + SumW'(vote_q);
  assign cnt_n     = cnt_q + 8'd1;
  assign five_best = (CmpW'(best_q) << 2) + CmpW'(best_q);
  assign six_sec   = (CmpW'(sec_q) << 2) + (CmpW'(sec_q) << 1);

  always_comb begin
    state_d    = state_q;
    score_d    = score_q;
    cnt_d      = cnt_q;
    lock_d     = lock_q;
    lock_idx_d = lock_idx_q;
    n_d        = n_q;
    r_d        = r_q;
    m_d        = m_q;
    den_d      = den_q;
    num_d      = num_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    decay_d    = decay_q;
    berr_d     = berr_q;
    bm_d       = bm_q;
    frac_d     = frac_q;
    vote_d     = vote_q;
    best_d     = best_q;
    sec_d      = sec_q;
    bi_d       = bi_q;
    acc_d      = acc_q;
    evt_d      = evt_q;
    ov_d       = ov_q && out_stall_i;
    oacc_d     = oacc_q;
    oevt_d     = oevt_q;
    oidx_d     = oidx_q;
    olock_d    = olock_q;

    case (state_q)
      bric_pkg::ST_IDLE: begin
        if (in_acc) begin
          n_d   = interval_samples_i[7:0];
          evt_d = 1'b0;
          if (en_q && interval_samples_i >= bric_pkg::MinInterval &&
              interval_samples_i <= bric_pkg::MaxInterval) begin
            acc_d   = 1'b1;
            state_d = bric_pkg::ST_SETUP;
          end else begin
            acc_d   = 1'b0;
            state_d = bric_pkg::ST_DONE;
          end
        end
      end
      bric_pkg::ST_SETUP: begin
        den_d   = bric_pkg::DenW'(sr_eff * bric_pkg::DenScale);
        r_d     = 2'd0;
        state_d = bric_pkg::ST_LOAD;
      end
      bric_pkg::ST_LOAD: begin
        num_d   = bric_pkg::NumW'({prod_nb, 16'd0}) +
                  bric_pkg::NumW'(den_q >> 1);
        rem_d   = '0;
        dcnt_d  = bric_pkg::DivCntW'(bric_pkg::NumW);
        decay_d = 1'b0;
        state_d = bric_pkg::ST_DIV;
      end
      bric_pkg::ST_DIV: begin
        // one quotient bit per cycle
        rem_d  = qbit ? bric_pkg::DenW'(trial - {1'b0, den_q})
                      : trial[bric_pkg::DenW-1:0];
        num_d  = {num_q[bric_pkg::NumW-2:0], qbit};
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == bric_pkg::DivCntW'(1)) begin
          if (decay_q) begin
            score_d[r_q] = num_d[SB-1:0];
            if (r_q == 2'd3) begin
              state_d = bric_pkg::ST_DONE;
            end else begin
              r_d     = r_q + 2'd1;
              state_d = bric_pkg::ST_DECAY;
            end
          end else begin
            m_d     = 3'd0;
            berr_d  = bric_pkg::ErrInit;
            bm_d    = 3'd0;
            state_d = bric_pkg::ST_ERR;
          end
        end
      end
      bric_pkg::ST_ERR: begin
        // strict less-than keeps the first multiple on a tie
        if (e < bric_pkg::XW'(berr_q)) begin
          berr_d = e[bric_pkg::ErrW-1:0];
          bm_d   = m_q;
        end
        m_d = m_q + 3'd1;
        if (m_q == 3'd7) begin
          state_d = bric_pkg::ST_FRAC;
        end
      end
      bric_pkg::ST_FRAC: begin
        frac_d = bric_pkg::FracW'(frac_full >> 3);
        if (berr_q < bric_pkg::ErrLimit) begin
          state_d = bric_pkg::ST_VOTE;
        end else begin
          state_d = bric_pkg::ST_NEXT;
        end
      end
      bric_pkg::ST_VOTE: begin
        vote_d  = vprod[32:16];
        state_d = bric_pkg::ST_ADD;
      end
      bric_pkg::ST_ADD: begin
        if (sum > SumW'({SB{1'b1}})) begin
          score_d[r_q] = {SB{1'b1}};
        end else begin
          score_d[r_q] = sum[SB-1:0];
        end
        state_d = bric_pkg::ST_NEXT;
      end
      bric_pkg::ST_NEXT: begin
        if (r_q == 2'd3) begin
          if (cnt_n >= 8'(DECISION_WINDOW)) begin
            cnt_d   = 8'd0;
            best_d  = score_q[0];
            sec_d   = '0;
            bi_d    = 2'd0;
            r_d     = 2'd1;
            state_d = bric_pkg::ST_SCAN;
          end else begin
            cnt_d   = cnt_n;
            state_d = bric_pkg::ST_DONE;
          end
        end else begin
          r_d     = r_q + 2'd1;
          state_d = bric_pkg::ST_LOAD;
        end
      end
      bric_pkg::ST_SCAN: begin
        if (score_q[r_q] > best_q) begin
          sec_d  = best_q;
          best_d = score_q[r_q];
          bi_d   = r_q;
        end else if (score_q[r_q] > sec_q) begin
          sec_d = score_q[r_q];
        end
        r_d = r_q + 2'd1;
        if (r_q == 2'd3) begin
          state_d = bric_pkg::ST_CHECK;
        end
      end
      bric_pkg::ST_CHECK: begin
        if (34'(best_q) > bric_pkg::LockMin && five_best > six_sec) begin
          lock_d     = 1'b1;
          lock_idx_d = bi_q;
          evt_d      = 1'b1;
          r_d        = 2'd0;
          state_d    = bric_pkg::ST_DECAY;
        end else begin
          state_d = bric_pkg::ST_DONE;
        end
      end
      bric_pkg::ST_DECAY: begin
        // score * 2 / 5 on the shared divider
        num_d   = bric_pkg::NumW'({score_q[r_q], 1'b0});
        den_d   = bric_pkg::DecayDiv;
        rem_d   = '0;
        dcnt_d  = bric_pkg::DivCntW'(bric_pkg::NumW);
        decay_d = 1'b1;
        state_d = bric_pkg::ST_DIV;
      end
      bric_pkg::ST_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          oacc_d  = acc_q;
          oevt_d  = evt_q;
          oidx_d  = lock_idx_q;
          olock_d = lock_q;
          state_d = bric_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bric_pkg::ST_IDLE;
      end
    endcase

    // enable cleared: drop all tracking (the user writes it only while idle; the block does not enforce this)
    if (cfg_wr && cfg_index_i == bric_pkg::RegEnable && !cfg_data_i[0]) begin
      for (int i = 0; i < bric_pkg::NumRates; i++) begin
        score_d[i] = '0;
      end
      cnt_d      = 8'd0;
      lock_d     = 1'b0;
      lock_idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bric_pkg::ST_IDLE;
      sr_q       <= bric_pkg::SrReset;
      en_q       <= 1'b1;
      for (int i = 0; i < bric_pkg::NumRates; i++) begin
        score_q[i] <= '0;
      end
      cnt_q      <= 8'd0;
      lock_q     <= 1'b0;
      lock_idx_q <= 2'd0;
      r_q        <= 2'd0;
      m_q        <= 3'd0;
      dcnt_q     <= '0;
      decay_q    <= 1'b0;
      acc_q      <= 1'b0;
      evt_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      score_q    <= score_d;
      cnt_q      <= cnt_d;
      lock_q     <= lock_d;
      lock_idx_q <= lock_idx_d;
      r_q        <= r_d;
      m_q        <= m_d;
      dcnt_q     <= dcnt_d;
      decay_q    <= decay_d;
      acc_q      <= acc_d;
      evt_q      <= evt_d;
      ov_q       <= ov_d;
      if (cfg_wr) begin
        if (cfg_index_i == bric_pkg::RegSampleRate) begin
          sr_q <= cfg_data_i;
        end else begin
          en_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_d_unused_guard: begin
      n_q     <= n_d;
      den_q   <= den_d;
      num_q   <= num_d;
      rem_q   <= rem_d;
      berr_q  <= berr_d;
      bm_q    <= bm_d;
      frac_q  <= frac_d;
      vote_q  <= vote_d;
      best_q  <= best_d;
      sec_q   <= sec_d;
      bi_q    <= bi_d;
      oacc_q  <= oacc_d;
      oevt_q  <= oevt_d;
      oidx_q  <= oidx_d;
      olock_q <= olock_d;
    end
  end

endmodule
